[design/adpcm_pkg.sv]
// shared types and constants of the 4-bit adpcm encoder
// no dependencies, imported by adpcm_4bit_encoder and by the testbench

package adpcm_pkg;

    localparam int SMP_W  = 16;
    localparam int STEP_W = 15;
    localparam int SCL_W  = 10;
    localparam int ACC_W  = 24;
    localparam int REM_W  = 18;

    localparam logic [STEP_W-1:0] STEP_MIN = 15'd127;
    localparam logic [STEP_W-1:0] STEP_MAX = 15'd24576;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_MUL,
        S_CLAMP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div;
        logic mul;
        logic clamp;
        logic emit;
    } t_ctrl;

    // step scale factor per magnitude code
    function automatic logic [SCL_W-1:0] scale_of(input logic [2:0] m);
        logic [SCL_W-1:0] s;
        case (m)
            3'd4:    s = 10'd307;
            3'd5:    s = 10'd409;
            3'd6:    s = 10'd512;
            3'd7:    s = 10'd614;
            default: s = 10'd230;
        endcase
        return s;
    endfunction

endpackage

[design/adpcm_4bit_encoder.sv]
// 4-bit adaptive differential pcm encoder, two samples per input word
// depends on adpcm_pkg for the state type, control struct and scale table
//
// pace set by the bit-serial quotient and the 2-bit-per-cycle shift-add step multiplier;
//   a word is accepted only in idle, after the byte of the previous word has been emitted
// a finished byte waits in the output register while the next word is accepted
// reset: synchronous active low, predictor 0, step 127, no byte pending

module adpcm_4bit_encoder
    import adpcm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [SMP_W-1:0]  i_first_sample,
    input  logic signed [SMP_W-1:0]  i_second_sample,
    input  logic                     i_restart,
    input  logic                     i_last_pair,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [7:0]               o_encoded_byte,
    output logic                     o_last_byte
);

    // control state
    t_state            r_state, n_state;
    t_ctrl             c;
    logic [2:0]        r_cnt;
    logic              r_half;
    logic              r_out_valid;

    // codec state
    logic signed [SMP_W-1:0] r_pred;
    logic [STEP_W-1:0]       r_step;

    // datapath
    logic signed [SMP_W-1:0] r_smp1, r_smp2;
    logic                    r_last;
    logic [REM_W-1:0]        r_rem;     // 4*|delta|, shrinks as quotient bits come out
    logic [REM_W-1:0]        r_div;     // 8*step, shifted right one bit per cycle
    logic                    r_sat;     // quotient would reach 8, code pins at 7
    logic [2:0]              r_q;
    logic                    r_neg;
    logic [ACC_W-1:0]        r_acc;     // step * scale, built two bits of scale per cycle
    logic [ACC_W-1:0]        r_mcand;
    logic [SCL_W-1:0]        r_scale;
    logic [3:0]              r_code_hi, r_code_lo;
    logic [7:0]              r_out_byte;
    logic                    r_out_last;

    logic accept_in, out_free;
    assign accept_in = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;

    // ---------------------------------------------------------------
    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_LOAD;
            S_LOAD:  n_state = S_DIV;
            S_DIV:   if (r_cnt == 3'd0) n_state = S_MUL;
            S_MUL:   if (r_cnt == 3'd0) n_state = S_CLAMP;
            S_CLAMP: n_state = r_half ? S_EMIT : S_LOAD;
            S_EMIT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // state decode
    always_comb begin
        c       = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_LOAD:  c.load  = 1'b1;
            S_DIV:   c.div   = 1'b1;
            S_MUL:   c.mul   = 1'b1;
            S_CLAMP: c.clamp = 1'b1;
            S_EMIT:  c.emit  = out_free;
            default: o_stall = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------
    // delta and magnitude of the sample in hand
    logic signed [SMP_W-1:0] cur_smp;
    logic signed [SMP_W:0]   delta;
    logic [SMP_W:0]          mag_full;
    assign cur_smp  = r_half ? r_smp2 : r_smp1;
    assign delta    = {cur_smp[SMP_W-1], cur_smp} - {r_pred[SMP_W-1], r_pred};
    assign mag_full = delta[SMP_W] ? (~delta + 1'b1) : delta;

    // one quotient bit per cycle
    logic             ge;
    logic [2:0]       n_q;
    logic [REM_W-1:0] n_rem;
    logic [2:0]       m_final;
    always_comb begin
        ge    = (r_rem >= r_div);
        n_q   = r_q;
        n_rem = r_rem;
        if (r_cnt != 3'd3 && !r_sat && ge) begin
            n_rem        = r_rem - r_div;
            n_q[r_cnt[1:0]] = 1'b1;
        end
        m_final = r_sat ? 3'd7 : n_q;
    end

    // predictor update: step*(2m+1)/8 toward zero, then saturate
    logic [18:0]         prod_d;
    logic [SMP_W-1:0]    adj;
    logic signed [17:0]  p_sum;
    logic signed [SMP_W-1:0] p_sat;
    always_comb begin
        prod_d = 19'(r_step) * 19'({r_q, 1'b1});
        adj    = prod_d[18:3];
        p_sum  = r_neg ? (18'(r_pred) - $signed({2'b00, adj}))
                       : (18'(r_pred) + $signed({2'b00, adj}));
        if (p_sum > 18'sd32767)
            p_sat = 16'sh7fff;
        else if (p_sum < -18'sd32768)
            p_sat = 16'sh8000;
        else
            p_sat = p_sum[SMP_W-1:0];
    end

    // one scale digit of the step multiply
    logic [ACC_W+1:0] partial;
    always_comb begin
        case (r_scale[1:0])
            2'd1:    partial = {2'b00, r_mcand};
            2'd2:    partial = {1'b0, r_mcand, 1'b0};
            2'd3:    partial = {2'b00, r_mcand} + {1'b0, r_mcand, 1'b0};
            default: partial = '0;
        endcase
    end

    // step clamp
    logic [SMP_W-1:0]  s_raw;
    logic [STEP_W-1:0] s_clamp;
    always_comb begin
        s_raw = r_acc[ACC_W-1:8];
        if (s_raw < 16'(STEP_MIN))
            s_clamp = STEP_MIN;
        else if (s_raw > 16'(STEP_MAX))
            s_clamp = STEP_MAX;
        else
            s_clamp = s_raw[STEP_W-1:0];
    end

    // ---------------------------------------------------------------
    // control and codec state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pred      <= '0;
            r_step      <= STEP_MIN;
        end else begin
            r_state <= n_state;
            if (accept_in) begin
                r_half <= 1'b0;
                if (i_restart) begin
                    r_pred <= '0;
                    r_step <= STEP_MIN;
                end
            end
            if (c.load)
                r_cnt <= 3'd3;
            else if (c.div)
                r_cnt <= (r_cnt == 3'd0) ? 3'd4 : r_cnt - 3'd1;
            else if (c.mul)
                r_cnt <= r_cnt - 3'd1;
            // predictor moves in the first multiply cycle, once the code is known
            if (c.mul && r_cnt == 3'd4)
                r_pred <= p_sat;
            if (c.clamp) begin
                r_step <= s_clamp;
                r_half <= 1'b1;
            end
            if (c.emit)
                r_out_valid <= 1'b1;
            else if (!i_stall)
                r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_smp1 <= i_first_sample;
            r_smp2 <= i_second_sample;
            r_last <= i_last_pair;
        end
        if (c.load) begin
            r_neg <= delta[SMP_W];
            r_rem <= {mag_full[SMP_W-1:0], 2'b00};
            r_div <= {r_step, 3'b000};
            r_sat <= 1'b0;
            r_q   <= '0;
        end
        if (c.div) begin
            if (r_cnt == 3'd3)
                r_sat <= ge;
            r_rem <= n_rem;
            r_div <= r_div >> 1;
            if (r_cnt == 3'd0) begin
                r_q     <= m_final;
                r_mcand <= ACC_W'(r_step);
                r_scale <= scale_of(m_final);
                r_acc   <= '0;
            end else begin
                r_q <= n_q;
            end
        end
        if (c.mul) begin
            r_acc   <= r_acc + partial[ACC_W-1:0];
            r_mcand <= r_mcand << 2;
            r_scale <= r_scale >> 2;
        end
        if (c.clamp) begin
            if (r_half)
                r_code_lo <= {r_neg, r_q};
            else
                r_code_hi <= {r_neg, r_q};
        end
        if (c.emit) begin
            r_out_byte <= {r_code_hi, r_code_lo};
            r_out_last <= r_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_encoded_byte = r_out_byte;
    assign o_last_byte    = r_out_last;

    // ---------------------------------------------------------------
    // checks
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step >= STEP_MIN) && (r_step <= STEP_MAX))
        else $error("step left its range");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in |=> o_stall)
        else $error("word accepted while previous word still in work");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= 3'd3))
        else $error("quotient counter out of range");

    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_sat) |-> (r_q == 3'd7))
        else $error("saturated quotient not pinned to seven");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> r_out_valid)
        else $error("finished byte not presented");

endmodule

[verif/tb.sv]
// self-checking bench for adpcm_4bit_encoder: drives sample pairs, predicts each byte
// depends on design/adpcm_pkg.sv and design/adpcm_4bit_encoder.sv
`timescale 1ns / 1ps

module tb;
    import adpcm_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_PAD    = 40;
    localparam int RANDOM_WORDS = 800;
    localparam int IDLE_PCT     = 17;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;
    localparam int SMP_MAX      = 32767;
    localparam int SMP_MIN      = -32768;
    localparam int STEP_LO      = 127;
    localparam int STEP_HI      = 24576;

    // one expected output word
    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
    } coded_word_t;

    // keeps its own copy of predictor and step, queues the bytes the encoder owes
    class pcm_scoreboard;
        logic signed [SMP_W-1:0] pred_val;
        logic [STEP_W-1:0]       step_val;
        int                      step_scale [8];
        coded_word_t             owed_bytes [$];
        int                      errors;

        function new();
            step_scale = '{230, 230, 230, 230, 307, 409, 512, 614};
            pred_val   = '0;
            step_val   = STEP_W'(STEP_LO);
            errors     = 0;
        endfunction

        function logic [3:0] encode_sample(logic signed [SMP_W-1:0] smp);
            int       delta;
            int       mag;
            int       quo;
            int       odd;
            int       p;
            int       s;
            logic [2:0] m;
            delta = int'(smp) - int'(pred_val);
            mag   = (delta < 0) ? -delta : delta;
            quo   = (mag * 4) / int'(step_val);
            m     = (quo > 7) ? 3'd7 : quo[2:0];
            odd   = 2 * int'(m) + 1;
            if (delta < 0)
                odd = -odd;
            // signed int division truncates toward zero
            p = int'(pred_val) + (int'(step_val) * odd) / 8;
            if (p > SMP_MAX)
                p = SMP_MAX;
            if (p < SMP_MIN)
                p = SMP_MIN;
            pred_val = p[SMP_W-1:0];
            s = (int'(step_val) * step_scale[m]) >> 8;
            if (s < STEP_LO)
                s = STEP_LO;
            if (s > STEP_HI)
                s = STEP_HI;
            step_val = s[STEP_W-1:0];
            return {(delta < 0), m};
        endfunction

        function void note_pair(logic signed [SMP_W-1:0] a, logic signed [SMP_W-1:0] b,
                                logic restart, logic last);
            coded_word_t w;
            logic [3:0]  hi;
            logic [3:0]  lo;
            if (restart) begin
                pred_val = '0;
                step_val = STEP_W'(STEP_LO);
            end
            hi = encode_sample(a);
            lo = encode_sample(b);
            w.code_byte = {hi, lo};
            w.last      = last;
            owed_bytes.push_back(w);
        endfunction

        function void check_byte(logic [7:0] code_byte, logic last);
            coded_word_t w;
            if (owed_bytes.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected byte %02h last %0b", code_byte, last);
                return;
            end
            w = owed_bytes.pop_front();
            if (w.code_byte !== code_byte || w.last !== last) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                             w.code_byte, w.last, code_byte, last);
            end
        endfunction

        function int pending();
            return owed_bytes.size();
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [SMP_W-1:0] i_first_sample;
    logic signed [SMP_W-1:0] i_second_sample;
    logic                    i_restart;
    logic                    i_last_pair;
    logic                    o_valid;
    logic                    i_stall;
    logic [7:0]              o_encoded_byte;
    logic                    o_last_byte;

    pcm_scoreboard sb = new();

    // idling controls, written by the main sequence
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int hold_left  = 0;     // receiver long hold-off, counted down by the receiver
    int cycle_cnt  = 0;

    adpcm_4bit_encoder u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_first_sample  (i_first_sample),
        .i_second_sample (i_second_sample),
        .i_restart       (i_restart),
        .i_last_pair     (i_last_pair),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_encoded_byte  (o_encoded_byte),
        .o_last_byte     (o_last_byte)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // monitor: values seen here are the ones from before the edge, both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_pair(i_first_sample, i_second_sample, i_restart, i_last_pair);
            if (o_valid && !i_stall)
                sb.check_byte(o_encoded_byte, o_last_byte);
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_stall   <= 1'b1;
                hold_left <= hold_left - 1;
            end else begin
                i_stall <= rx_idle_en && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // offer one word, with random idle cycles ahead of it; returns on the accepting edge
    // with valid still high, so back-to-back words never drop valid
    task automatic send_word(input logic signed [SMP_W-1:0] a,
                             input logic signed [SMP_W-1:0] b,
                             input logic restart, input logic last);
        while (tx_idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_first_sample  <= a;
        i_second_sample <= b;
        i_restart       <= restart;
        i_last_pair     <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // drop valid and wait until every owed byte has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // next sample for a buffer: full random, random walk around prev, or extremes
    function automatic logic signed [SMP_W-1:0] pick_sample(int mode, int span,
                                                            logic signed [SMP_W-1:0] prev);
        int v;
        case (mode)
            0, 1: v = int'($signed(16'($urandom)));
            8, 9: begin
                case ($urandom_range(0, 5))
                    0: v = SMP_MAX;
                    1: v = SMP_MIN;
                    2: v = 0;
                    3: v = 1;
                    4: v = -1;
                    default: v = int'($signed(16'($urandom)));
                endcase
            end
            default: begin
                v = int'(prev) + $urandom_range(0, 2 * span) - span;
                if (v > SMP_MAX)
                    v = SMP_MAX;
                if (v < SMP_MIN)
                    v = SMP_MIN;
            end
        endcase
        return v[SMP_W-1:0];
    endfunction

    initial begin
        int                      sent;
        int                      buf_len;
        int                      mode;
        int                      span;
        bit                      broken;
        logic                    rs;
        logic                    lp;
        logic signed [SMP_W-1:0] a;
        logic signed [SMP_W-1:0] b;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_first_sample  = '0;
        i_second_sample = '0;
        i_restart       = 1'b0;
        i_last_pair     = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        // no restart on the very first word: encoder runs from its reset state
        send_word(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_word(16'sd1, -16'sd1, 1'b0, 1'b0);
        // full-scale positive run: step grows toward its ceiling, predictor saturates high
        repeat (5) send_word(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
        // full-scale negative run: predictor saturates low
        repeat (5) send_word(16'sh8000, 16'sh8000, 1'b0, 1'b0);
        // end of buffer only tags the byte, state carries on
        send_word(16'sh8000, 16'sh7fff, 1'b0, 1'b1);
        send_word(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
        // restart mid-stream, which puts the step at its floor, then zero samples hold it there
        send_word(16'sd0, 16'sd0, 1'b1, 1'b0);
        repeat (2) send_word(16'sd0, 16'sd0, 1'b0, 1'b0);
        send_word(16'sd100, -16'sd100, 1'b0, 1'b0);
        send_word(16'sd31, -16'sd32, 1'b0, 1'b1);
        // restart and last together, single-word buffer
        send_word(-16'sd5000, 16'sd5000, 1'b1, 1'b1);
        send_word(16'sh5555, 16'shaaaa, 1'b1, 1'b0);
        send_word(16'shaaaa, 16'sh5555, 1'b0, 1'b1);
        drain();

        // back-pressure: receiver holds off while the sender keeps offering words,
        // so the output register fills and the input stalls
        tx_idle_en = 1'b0;
        hold_left  = HOLD_CYCLES;
        for (int k = 0; k < 20; k++) begin
            a = pick_sample(0, 0, '0);
            b = pick_sample(0, 0, '0);
            send_word(a, b, (k == 0), (k == 19));
        end
        tx_idle_en = 1'b1;
        drain();

        // random buffers: mostly restart ... last framed, some with random flags
        sent = 0;
        a    = '0;
        while (sent < RANDOM_WORDS) begin
            // a stretch with no idling on either side
            tx_idle_en = !(sent >= 300 && sent < 450);
            rx_idle_en = tx_idle_en;
            buf_len = $urandom_range(1, 40);
            mode    = $urandom_range(0, 9);
            case ($urandom_range(0, 2))
                0: span = 16;
                1: span = 512;
                default: span = 8000;
            endcase
            broken = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < buf_len; k++) begin
                rs = broken ? 1'($urandom_range(0, 1)) : (k == 0);
                lp = broken ? 1'($urandom_range(0, 1)) : (k == buf_len - 1);
                a  = pick_sample(mode, span, a);
                b  = pick_sample(mode, span, a);
                send_word(a, b, rs, lp);
                a  = b;
                sent++;
            end
            // now and then the sender waits for every byte before the next buffer
            if ($urandom_range(0, 19) == 0)
                drain();
        end
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
